// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define PITT_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("point-in-triangle check failed");

// Check that a condition implies another in the same cycle.
`define PITT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("point-in-triangle implication failed");

`endif

// ===== design/pitt_pkg.sv =====
// Shared types and constants of the point-in-triangle test unit.
package pitt_pkg;

  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned TOL_W      = 16;
  localparam int unsigned TOL_FRAC   = 8;
  localparam int unsigned PIPE_DEPTH = 5;
  localparam int unsigned NUM_VTX    = 6;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd51;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AX  = 3'd0,
    CFG_AY  = 3'd1,
    CFG_BX  = 3'd2,
    CFG_BY  = 3'd3,
    CFG_CX  = 3'd4,
    CFG_CY  = 3'd5,
    CFG_TOL = 3'd6
  } cfg_idx_e;

  // Coordinate differences formed in the first stage.
  localparam int unsigned NUM_DIFF = 10;
  localparam int unsigned DF_BAX = 0;  // bx - ax
  localparam int unsigned DF_CAY = 1;  // cy - ay
  localparam int unsigned DF_BAY = 2;  // by - ay
  localparam int unsigned DF_CAX = 3;  // cx - ax
  localparam int unsigned DF_PAX = 4;  // px - ax
  localparam int unsigned DF_PAY = 5;  // py - ay
  localparam int unsigned DF_BPX = 6;  // bx - px
  localparam int unsigned DF_CPY = 7;  // cy - py
  localparam int unsigned DF_BPY = 8;  // by - py
  localparam int unsigned DF_CPX = 9;  // cx - px

  // Area k is MUL_L[2k]*MUL_R[2k] - MUL_L[2k+1]*MUL_R[2k+1].
  // Area 0 is the full triangle, areas 1..3 the sub-triangles.
  localparam int unsigned NUM_AREA = 4;
  localparam int unsigned NUM_MUL  = 2 * NUM_AREA;
  localparam int unsigned MUL_L [NUM_MUL] = '{DF_BAX, DF_BAY, DF_BPX, DF_BPY,
                                              DF_PAX, DF_PAY, DF_BAX, DF_BAY};
  localparam int unsigned MUL_R [NUM_MUL] = '{DF_CAY, DF_CAX, DF_CPY, DF_CPX,
                                              DF_CAY, DF_CAX, DF_PAY, DF_PAX};

endpackage

// ===== design/pitt_cfg.sv =====
// Configuration registers: triangle vertices and tolerance.
module pitt_cfg #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [pitt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pitt_pkg::CFG_W-1:0]      cfg_data_i,
  output logic [COORD_WIDTH-1:0]          vtx_o [pitt_pkg::NUM_VTX],
  output logic [pitt_pkg::TOL_W-1:0]      tol_o
);
  import pitt_pkg::*;

  logic [CFG_W-1:0] vtx_q [NUM_VTX];
  logic [TOL_W-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VTX; i++) begin
        vtx_q[i] <= '0;
      end
      tol_q <= TOL_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_AX:  vtx_q[0] <= cfg_data_i;
        CFG_AY:  vtx_q[1] <= cfg_data_i;
        CFG_BX:  vtx_q[2] <= cfg_data_i;
        CFG_BY:  vtx_q[3] <= cfg_data_i;
        CFG_CX:  vtx_q[4] <= cfg_data_i;
        CFG_CY:  vtx_q[5] <= cfg_data_i;
        CFG_TOL: tol_q    <= cfg_data_i[TOL_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Take the low coordinate bits; a wider coordinate sees a non-negative value.
  for (genvar g = 0; g < NUM_VTX; g++) begin : g_vtx
    if (COORD_WIDTH <= CFG_W) begin : g_narrow
      assign vtx_o[g] = vtx_q[g][COORD_WIDTH-1:0];
    end else begin : g_wide
      assign vtx_o[g] = {{(COORD_WIDTH-CFG_W){1'b0}}, vtx_q[g]};
    end
  end

  assign tol_o = tol_q;

endmodule

// ===== design/pitt_diff.sv =====
// Stage 1: coordinate differences between the vertices and between the point and the vertices.
module pitt_diff #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [COORD_WIDTH-1:0]        point_x_i,
  input  logic [COORD_WIDTH-1:0]        point_y_i,
  input  logic [COORD_WIDTH-1:0]        vtx_i [pitt_pkg::NUM_VTX],
  output logic                          valid_o,
  output logic signed [COORD_WIDTH:0]   diff_o [pitt_pkg::NUM_DIFF]
);
  import pitt_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 1;

  logic signed [DW-1:0] ax, ay, bx, by, cx, cy, px, py;
  logic signed [DW-1:0] diff_d [NUM_DIFF];
  logic signed [DW-1:0] diff_q [NUM_DIFF];
  logic                 valid_q;

  assign ax = $signed({vtx_i[0][COORD_WIDTH-1], vtx_i[0]});
  assign ay = $signed({vtx_i[1][COORD_WIDTH-1], vtx_i[1]});
  assign bx = $signed({vtx_i[2][COORD_WIDTH-1], vtx_i[2]});
  assign by = $signed({vtx_i[3][COORD_WIDTH-1], vtx_i[3]});
  assign cx = $signed({vtx_i[4][COORD_WIDTH-1], vtx_i[4]});
  assign cy = $signed({vtx_i[5][COORD_WIDTH-1], vtx_i[5]});
  assign px = $signed({point_x_i[COORD_WIDTH-1], point_x_i});
  assign py = $signed({point_y_i[COORD_WIDTH-1], point_y_i});

  always_comb begin
    diff_d[DF_BAX] = bx - ax;
    diff_d[DF_CAY] = cy - ay;
    diff_d[DF_BAY] = by - ay;
    diff_d[DF_CAX] = cx - ax;
    diff_d[DF_PAX] = px - ax;
    diff_d[DF_PAY] = py - ay;
    diff_d[DF_BPX] = bx - px;
    diff_d[DF_CPY] = cy - py;
    diff_d[DF_BPY] = by - py;
    diff_d[DF_CPX] = cx - px;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
  end

  assign valid_o = valid_q;
  assign diff_o  = diff_q;

endmodule

// ===== design/pitt_area.sv =====
// Stages 2 and 3: edge products, then absolute doubled areas.
module pitt_area #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [COORD_WIDTH:0]         diff_i [pitt_pkg::NUM_DIFF],
  output logic                                valid_o,
  output logic [2*COORD_WIDTH+2:0]            area_o [pitt_pkg::NUM_AREA]
);
  import pitt_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned AW = PW + 1;

  logic signed [PW-1:0] prod_q [NUM_MUL];
  logic [AW-1:0]        area_d [NUM_AREA];
  logic [AW-1:0]        area_q [NUM_AREA];
  logic                 valid1_q, valid2_q;

  // One multiplier per product, registered before the subtract.
  always_ff @(posedge clk_i) begin
    for (int m = 0; m < NUM_MUL; m++) begin
      prod_q[m] <= diff_i[MUL_L[m]] * diff_i[MUL_R[m]];
    end
  end

  for (genvar k = 0; k < NUM_AREA; k++) begin : g_area
    logic signed [AW-1:0] det;
    assign det = $signed({prod_q[2*k][PW-1], prod_q[2*k]})
               - $signed({prod_q[2*k+1][PW-1], prod_q[2*k+1]});
    assign area_d[k] = det[AW-1] ? AW'(-det) : AW'(det);
  end

  always_ff @(posedge clk_i) begin
    area_q <= area_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  assign valid_o = valid2_q;
  assign area_o  = area_q;

endmodule

// ===== design/pitt_cmp.sv =====
// Stages 4 and 5: area excess, then compare against the tolerance.
module pitt_cmp #(
  parameter int unsigned COORD_WIDTH   = 16,
  parameter int unsigned FRACTION_BITS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [2*COORD_WIDTH+2:0]        area_i [pitt_pkg::NUM_AREA],
  input  logic [pitt_pkg::TOL_W-1:0]      tol_i,
  output logic                            valid_o,
  output logic                            covered_o
);
  import pitt_pkg::*;

  localparam int unsigned AW    = 2 * COORD_WIDTH + 3;
  localparam int unsigned EW    = AW + 2;
  localparam int unsigned LW    = EW + TOL_FRAC;
  localparam int unsigned RW    = TOL_W + 2 * FRACTION_BITS;
  localparam int unsigned CMP_W = (LW > RW) ? LW : RW;

  logic [EW-1:0]    excess_d, excess_q;
  logic [CMP_W-1:0] lhs, rhs;
  logic             valid1_q, valid2_q, covered_q;

  // Absolute sub-areas sum to at least the full area, so the excess never goes negative.
  assign excess_d = EW'(area_i[1]) + EW'(area_i[2]) + EW'(area_i[3]) - EW'(area_i[0]);

  always_ff @(posedge clk_i) begin
    excess_q <= excess_d;
  end

  // Align both sides to the same fraction: excess * 2^8 < tol * 2^(2F).
  assign lhs = CMP_W'(excess_q) << TOL_FRAC;
  assign rhs = CMP_W'(tol_i) << (2 * FRACTION_BITS);

  always_ff @(posedge clk_i) begin
    covered_q <= lhs < rhs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  assign valid_o   = valid2_q;
  assign covered_o = covered_q & valid2_q;

endmodule

// ===== design/point_in_triangle_test_unit.sv =====
// Point-in-triangle test unit: top level.
// Tests one query point per clock against the triangle held in the vertex
// registers, by comparing the sum of the three sub-triangle areas with the
// full area plus the tolerance. A request is taken whenever start_i is high;
// busy_o stays low, so a new point may follow in every cycle. The answer
// appears on covered_o with done_o high for one cycle, after one register
// stage each for the coordinate differences, the multipliers, the area
// subtract and absolute value, the excess sum, and the tolerance compare.
// Results cannot be held off. Write the vertex and tolerance registers only
// while no request is in flight; the configuration port is always ready and
// takes effect at the next edge.
module point_in_triangle_test_unit #(
  parameter int unsigned COORD_WIDTH   = 16,
  parameter int unsigned FRACTION_BITS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [COORD_WIDTH-1:0]          point_x_i,
  input  logic [COORD_WIDTH-1:0]          point_y_i,
  output logic                            done_o,
  output logic                            covered_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pitt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pitt_pkg::CFG_W-1:0]      cfg_data_i
);
  import pitt_pkg::*;

  logic [COORD_WIDTH-1:0]     vtx     [NUM_VTX];
  logic [TOL_W-1:0]           tol;
  logic                       diff_valid;
  logic signed [COORD_WIDTH:0] diff   [NUM_DIFF];
  logic                       area_valid;
  logic [2*COORD_WIDTH+2:0]   area    [NUM_AREA];

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  pitt_cfg #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .vtx_o       (vtx),
    .tol_o       (tol)
  );

  pitt_diff #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_diff (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i & ~busy_o),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .vtx_i     (vtx),
    .valid_o   (diff_valid),
    .diff_o    (diff)
  );

  pitt_area #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_area (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (diff_valid),
    .diff_i  (diff),
    .valid_o (area_valid),
    .area_o  (area)
  );

  pitt_cmp #(
    .COORD_WIDTH   (COORD_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cmp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (area_valid),
    .area_i    (area),
    .tol_i     (tol),
    .valid_o   (done_o),
    .covered_o (covered_o)
  );

endmodule

// ===== design/pitt_checker.sv =====
// Port-level checks of the point-in-triangle test unit and their binding.
`include "assert_macros.svh"

module pitt_sva (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic covered_o,
  input logic cfg_ready_o
);
  import pitt_pkg::*;

  logic                  req;
  logic [PIPE_DEPTH-1:0] req_q;

  assign req = start_i && !busy_o;

  // Track accepted requests through the fixed pipeline depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
    end else begin
      req_q <= {req_q[PIPE_DEPTH-2:0], req};
    end
  end

  // The pipeline never holds off a request or a configuration write.
  `PITT_ASSERT(a_never_busy, !busy_o)
  `PITT_ASSERT(a_cfg_ready, cfg_ready_o)

  // Every request yields exactly one result after the fixed pipeline depth.
  `PITT_ASSERT(a_done_latency, done_o == req_q[PIPE_DEPTH-1])

  // No coverage flag without a result strobe.
  `PITT_ASSERT_IMPLY(a_covered_strobed, !done_o, !covered_o)

endmodule

bind point_in_triangle_test_unit pitt_sva u_pitt_sva (.*);
